// File: src/affbp_pkg.sv
// ----------------------------------------------------------------------------
// affbp_pkg
// Shared constants, types and codes for the atlas first-fit block placer.
// ----------------------------------------------------------------------------
package affbp_pkg;

  localparam int BLOCK_PIXELS = 32;
  localparam int MAX_COLS     = 64;
  localparam int MAX_ROWS     = 64;

  localparam int BLOCK_SHIFT = $clog2(BLOCK_PIXELS);
  localparam int REQ_W       = 12;
  localparam int SIZE_W      = 7;
  localparam int PLACE_W     = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int LEN_W       = REQ_W + 1 - BLOCK_SHIFT;
  localparam int GRID_W      = MAX_COLS;
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int ROW_W       = $clog2(MAX_ROWS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_COLS = 1'b0,
    CFG_GRID_ROWS = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_DRAIN,
    S_RUN_INIT,
    S_RUN,
    S_UPD_RD,
    S_UPD_WR,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_start;
    logic rd_issue;
    logic run_init;
    logic run_step;
    logic next_row;
    logic pick;
    logic upd_wr;
    logic res_load;
  } dp_cmd_t;

  typedef struct packed {
    logic bad;
    logic rd_last;
    logic run_done;
    logic hit;
    logic row_last;
    logic upd_last;
  } dp_sts_t;

endpackage

// File: src/affbp_req_if.sv
// ----------------------------------------------------------------------------
// affbp_req_if
// Request channel: rectangle size in pixels.
// ----------------------------------------------------------------------------
interface affbp_req_if;
  logic                         valid;
  logic                         ready;
  logic [affbp_pkg::REQ_W-1:0]  req_width;
  logic [affbp_pkg::REQ_W-1:0]  req_height;

  modport source (output valid, output req_width, output req_height, input ready);
  modport sink   (input valid, input req_width, input req_height, output ready);
endinterface

// File: src/affbp_res_if.sv
// ----------------------------------------------------------------------------
// affbp_res_if
// Result channel: found flag and top-left pixel coordinates.
// ----------------------------------------------------------------------------
interface affbp_res_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [affbp_pkg::PLACE_W-1:0] place_x;
  logic [affbp_pkg::PLACE_W-1:0] place_y;

  modport source (output valid, output found, output place_x, output place_y, input ready);
  modport sink   (input valid, input found, input place_x, input place_y, output ready);
endinterface

// File: src/atlas_first_fit_block_placer.sv
// ----------------------------------------------------------------------------
// atlas_first_fit_block_placer
// First-fit placement of rectangles in a grid of up to 64x64 32-pixel atlas blocks.
// ----------------------------------------------------------------------------
// req (sink): a request transaction carries req_width and req_height in pixels.
// res (source): one result per request: found, place_x, place_y (0 on miss).
// cfg: write grid_cols (index 0) or grid_rows (index 1); each write clears the
// grid. Write only while no request is in flight.
// One request is searched at a time; req.ready is high only when idle.
// The search time is set by the single-port row store (one row read per
// cycle) and the one-bit-a-cycle free run search.
// A finished result sits in the output register; the next request is taken
// while it waits. A second result waits in the final state until res is
// taken, so a stalled receiver stalls the block with nothing lost.
// Reset clears the grid at once through per-row valid bits and sets both
// sizes to 64.
// ----------------------------------------------------------------------------
module atlas_first_fit_block_placer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [affbp_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [affbp_pkg::SIZE_W-1:0]    cfg_wdata,
  affbp_req_if.sink                       req,
  affbp_res_if.source                     res
);
  import affbp_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  affbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  affbp_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .req_width  (req.req_width),
    .req_height (req.req_height),
    .cmd        (cmd),
    .sts        (sts),
    .found      (res.found),
    .place_x    (res.place_x),
    .place_y    (res.place_y)
  );

endmodule

// File: src/affbp_ctrl.sv
// ----------------------------------------------------------------------------
// affbp_ctrl
// Sequencer for the placement search, grid update and result hand-off.
// ----------------------------------------------------------------------------
module affbp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output affbp_pkg::dp_cmd_t cmd,
  input  affbp_pkg::dp_sts_t sts
);
  import affbp_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = sts.bad ? S_FINISH : S_READ;
      end
      S_READ: begin
        if (sts.rd_last) state_next = S_DRAIN;
      end
      S_DRAIN:    state_next = S_RUN_INIT;
      S_RUN_INIT: state_next = S_RUN;
      S_RUN: begin
        if (sts.run_done) begin
          if (sts.hit) begin
            state_next = S_UPD_RD;
          end else if (sts.row_last) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_UPD_RD: state_next = S_UPD_WR;
      S_UPD_WR: begin
        state_next = sts.upd_last ? S_FINISH : S_UPD_RD;
      end
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_CHECK: begin
        cmd.rd_start = !sts.bad;
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
      end
      S_RUN_INIT: begin
        cmd.run_init = 1'b1;
      end
      S_RUN: begin
        if (!sts.run_done) begin
          cmd.run_step = 1'b1;
        end else if (sts.hit) begin
          cmd.pick = 1'b1;
        end else if (!sts.row_last) begin
          cmd.next_row = 1'b1;
          cmd.rd_start = 1'b1;
        end
      end
      S_UPD_WR: begin
        cmd.upd_wr = 1'b1;
      end
      S_FINISH: begin
        cmd.res_load = out_free;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> out_valid)
    else $error("result load did not raise valid");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_CHECK))
    else $error("accepted transaction did not start a search");
`endif

endmodule

// File: src/affbp_dp.sv
// ----------------------------------------------------------------------------
// affbp_dp
// Occupancy grid store, window accumulation, free-run search and result regs.
// ----------------------------------------------------------------------------
module affbp_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [affbp_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [affbp_pkg::SIZE_W-1:0]     cfg_wdata,
  input  logic [affbp_pkg::REQ_W-1:0]      req_width,
  input  logic [affbp_pkg::REQ_W-1:0]      req_height,
  input  affbp_pkg::dp_cmd_t               cmd,
  output affbp_pkg::dp_sts_t               sts,
  output logic                             found,
  output logic [affbp_pkg::PLACE_W-1:0]    place_x,
  output logic [affbp_pkg::PLACE_W-1:0]    place_y
);
  import affbp_pkg::*;

  function automatic logic [LEN_W-1:0] blocks_for(input logic [REQ_W-1:0] pixels);
    logic [REQ_W:0] sum;
    sum = {1'b0, pixels} + (REQ_W+1)'(BLOCK_PIXELS - 1);
    return LEN_W'(sum >> BLOCK_SHIFT);
  endfunction

  logic [SIZE_W-1:0]   grid_cols;
  logic [SIZE_W-1:0]   grid_rows;
  logic [SIZE_W-1:0]   cols_eff;
  logic [SIZE_W-1:0]   rows_eff;
  logic                cfg_clear;

  logic [LEN_W-1:0]    lw;
  logic [LEN_W-1:0]    lh;
  logic [ROW_W-1:0]    py;
  logic [ROW_W-1:0]    k;
  logic [ROW_W-1:0]    addr;
  logic [LEN_W-1:0]    step;
  logic [GRID_W-1:0]   acc;
  logic [GRID_W-1:0]   freev;
  logic [GRID_W-1:0]   runv;
  logic [GRID_W-1:0]   mask;
  logic [GRID_W-1:0]   colmask;
  logic [GRID_W-1:0]   win_mask;
  logic [COL_W-1:0]    px;
  logic [COL_W-1:0]    first_free;
  logic                hit_q;

  logic [GRID_W-1:0]   mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_valid;
  logic [GRID_W-1:0]   rd_data;
  logic                rd_vld;
  logic                rd_pend;
  logic [GRID_W-1:0]   row_word;

  // size registers, saturated on use
  assign cols_eff  = (grid_cols > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : grid_cols;
  assign rows_eff  = (grid_rows > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : grid_rows;
  assign cfg_clear = cfg_wr_en &&
                     (cfg_addr == CFG_GRID_COLS || cfg_addr == CFG_GRID_ROWS);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= SIZE_W'(MAX_COLS);
      grid_rows <= SIZE_W'(MAX_ROWS);
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_GRID_COLS: grid_cols <= cfg_wdata;
        CFG_GRID_ROWS: grid_rows <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // grid store with per-row valid bits
  assign addr     = py + k;
  assign row_word = rd_vld ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      row_valid <= '0;
    end else if (cmd.upd_wr) begin
      row_valid[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_wr) mem[addr] <= row_word | mask;
    rd_data <= mem[addr];
    rd_vld  <= row_valid[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_issue;
    end
  end

  // column limit, lowest free run start and window mask
  always_comb begin
    for (int i = 0; i < GRID_W; i++) begin
      colmask[i] = SIZE_W'(i) < cols_eff;
    end
  end

  always_comb begin
    first_free = '0;
    for (int i = GRID_W - 1; i >= 0; i--) begin
      if (runv[i]) first_free = COL_W'(i);
    end
  end

  always_comb begin
    for (int i = 0; i < GRID_W; i++) begin
      win_mask[i] = (LEN_W'(i) >= LEN_W'(first_free)) &&
                    (LEN_W'(i) < LEN_W'(first_free) + lw);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lw <= blocks_for(req_width);
      lh <= blocks_for(req_height);
    end

    if (cmd.load) begin
      py <= '0;
    end else if (cmd.next_row) begin
      py <= py + ROW_W'(1);
    end

    if (cmd.rd_start || cmd.pick) begin
      k <= '0;
    end else if (cmd.rd_issue || cmd.upd_wr) begin
      k <= k + ROW_W'(1);
    end

    if (cmd.rd_start) begin
      acc <= '0;
    end else if (rd_pend) begin
      acc <= acc | row_word;
    end

    if (cmd.run_init) begin
      freev <= ~acc & colmask;
      runv  <= ~acc & colmask;
      step  <= LEN_W'(1);
    end else if (cmd.run_step) begin
      runv <= freev & (runv >> 1);
      step <= step + LEN_W'(1);
    end

    if (cmd.load) begin
      hit_q <= 1'b0;
    end else if (cmd.pick) begin
      hit_q <= 1'b1;
      px    <= first_free;
      mask  <= win_mask;
    end

    if (cmd.res_load) begin
      found   <= hit_q;
      place_x <= hit_q ? (PLACE_W'(px) << BLOCK_SHIFT) : '0;
      place_y <= hit_q ? (PLACE_W'(py) << BLOCK_SHIFT) : '0;
    end
  end

  // status
  assign sts.bad      = (lw == '0) || (lh == '0) ||
                        (lw > LEN_W'(cols_eff)) || (lh > LEN_W'(rows_eff));
  assign sts.rd_last  = LEN_W'(k) == (lh - LEN_W'(1));
  assign sts.upd_last = LEN_W'(k) == (lh - LEN_W'(1));
  assign sts.run_done = step == lw;
  assign sts.hit      = |runv;
  assign sts.row_last = (LEN_W'(py) + lh) >= LEN_W'(rows_eff);

`ifndef SYNTHESIS
  a_read_in_grid: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |-> (LEN_W'(py) + LEN_W'(k)) < LEN_W'(rows_eff))
    else $error("row read beyond atlas height");

  a_write_after_pick: assert property (@(posedge clk) disable iff (rst)
    cmd.upd_wr |-> hit_q)
    else $error("grid written without a placement");

  a_window_free: assert property (@(posedge clk) disable iff (rst)
    cmd.pick |=> ((mask & acc) == '0) && (mask != '0))
    else $error("chosen window overlaps used blocks");
`endif

endmodule

// File: tb/atlas_first_fit_block_placer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// atlas_first_fit_block_placer_tb
// Self-checking bench for the first-fit atlas block placer.
// Requests are queued by the stimulus process and driven by a clocked driver.
// Each accepted request is placed in a local copy of the occupancy grid to
// predict found, place_x and place_y. A clocked monitor compares every result
// transaction in order. Phases cover several atlas sizes and both size
// extremes, with sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module atlas_first_fit_block_placer_tb;
  import affbp_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_PRINTS   = 40;
  localparam int HOLD_CYCLES  = 3000;

  typedef struct packed {
    logic [REQ_W-1:0] w;
    logic [REQ_W-1:0] h;
  } rect_t;

  typedef struct packed {
    logic               found;
    logic [PLACE_W-1:0] x;
    logic [PLACE_W-1:0] y;
  } placement_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr  = '0;
  logic [SIZE_W-1:0]    cfg_wdata = '0;
  logic                 hold_arm  = 1'b0;

  affbp_req_if req_ch();
  affbp_res_if res_ch();

  atlas_first_fit_block_placer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .res       (res_ch)
  );

  rect_t             rect_q[$];
  placement_t        placement_q[$];
  logic [GRID_W-1:0] occ_rows [MAX_ROWS];
  logic [SIZE_W-1:0] model_cols;
  logic [SIZE_W-1:0] model_rows;
  int                send_idle_pct  = 0;
  int                recv_stall_pct = 0;
  int                error_cnt      = 0;
  int                cycle_cnt      = 0;
  int                submitted_cnt  = 0;
  int                accepted_cnt   = 0;
  int                hold_len       = 0;
  int                hold_left      = 0;

  always #CLK_HALF clk = ~clk;

  function automatic placement_t place_rect(rect_t r);
    placement_t p;
    int lw, lh, cols, rows, py, px, ty;
    logic [63:0] mask;
    bit free_win, done;
    p    = '0;
    lw   = (int'(r.w) + BLOCK_PIXELS - 1) / BLOCK_PIXELS;
    lh   = (int'(r.h) + BLOCK_PIXELS - 1) / BLOCK_PIXELS;
    cols = (model_cols > MAX_COLS) ? MAX_COLS : int'(model_cols);
    rows = (model_rows > MAX_ROWS) ? MAX_ROWS : int'(model_rows);
    if (lw == 0 || lh == 0 || lw > cols || lh > rows) begin
      return p;
    end
    done = 1'b0;
    for (py = 0; py + lh <= rows && !done; py++) begin
      for (px = 0; px + lw <= cols && !done; px++) begin
        mask     = ((lw >= 64) ? {64{1'b1}} : ((64'd1 << lw) - 64'd1)) << px;
        free_win = 1'b1;
        for (ty = py; ty < py + lh; ty++) begin
          if ((occ_rows[ty] & mask) != '0) begin
            free_win = 1'b0;
          end
        end
        if (free_win) begin
          for (ty = py; ty < py + lh; ty++) begin
            occ_rows[ty] = occ_rows[ty] | mask;
          end
          p.found = 1'b1;
          p.x     = PLACE_W'(px * BLOCK_PIXELS);
          p.y     = PLACE_W'(py * BLOCK_PIXELS);
          done    = 1'b1;
        end
      end
    end
    return p;
  endfunction

  function automatic rect_t rand_rect();
    rect_t r;
    int cols, rows, sel;
    cols = (model_cols > MAX_COLS) ? MAX_COLS : int'(model_cols);
    rows = (model_rows > MAX_ROWS) ? MAX_ROWS : int'(model_rows);
    if (cols == 0) cols = 1;
    if (rows == 0) rows = 1;
    sel = $urandom_range(99);
    if (sel < 8) begin
      r.w = REQ_W'($urandom_range(4095));
      r.h = REQ_W'($urandom_range(4095));
    end else if (sel < 12) begin
      r.w = $urandom_range(1) ? '0 : REQ_W'($urandom_range(4095));
      r.h = (r.w == '0) ? REQ_W'($urandom_range(4095)) : '0;
    end else if (sel < 32) begin
      r.w = REQ_W'(BLOCK_PIXELS * $urandom_range(1, cols));
      r.h = REQ_W'(BLOCK_PIXELS * $urandom_range(1, rows));
    end else begin
      r.w = REQ_W'($urandom_range(1, BLOCK_PIXELS * ((cols + 1) / 2)));
      r.h = REQ_W'($urandom_range(1, BLOCK_PIXELS * ((rows + 1) / 2)));
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    error_cnt++;
    if (error_cnt <= MAX_PRINTS) begin
      $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    end
  endtask

  task automatic push_rect(input int w, input int h);
    rect_q.push_back(rect_t'{REQ_W'(w), REQ_W'(h)});
    submitted_cnt++;
  endtask

  task automatic wait_drained();
    while (accepted_cnt != submitted_cnt || placement_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // any size write clears the whole grid
  task automatic write_size(input cfg_idx_t idx, input int val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= SIZE_W'(val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_GRID_COLS) begin
      model_cols = SIZE_W'(val);
    end else begin
      model_rows = SIZE_W'(val);
    end
    foreach (occ_rows[i]) occ_rows[i] = '0;
  endtask

  task automatic run_phase(input int cols, input int rows, input int s_idle,
                           input int r_stall, input int n);
    write_size(CFG_GRID_COLS, cols);
    write_size(CFG_GRID_ROWS, rows);
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    repeat (n) begin
      rect_q.push_back(rand_rect());
      submitted_cnt++;
    end
    wait_drained();
  endtask

  // request driver
  always @(posedge clk) begin
    rect_t cur;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        placement_q.push_back(place_rect(rect_t'{req_ch.req_width, req_ch.req_height}));
        accepted_cnt++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (rect_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur = rect_q.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.req_width  <= cur.w;
          req_ch.req_height <= cur.h;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    placement_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (placement_q.size() == 0) begin
          report_mismatch("result transaction with no request outstanding");
        end else begin
          want = placement_q.pop_front();
          if (res_ch.found !== want.found)
            report_mismatch($sformatf("found %b, want %b", res_ch.found, want.found));
          if (res_ch.place_x !== want.x)
            report_mismatch($sformatf("place_x %0d, want %0d", res_ch.place_x, want.x));
          if (res_ch.place_y !== want.y)
            report_mismatch($sformatf("place_y %0d, want %0d", res_ch.place_y, want.y));
        end
      end
      res_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_arm) begin
      hold_left <= hold_len;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("atlas_first_fit_block_placer test failed");
      $finish;
    end
  end

  initial begin
    req_ch.valid      = 1'b0;
    req_ch.req_width  = '0;
    req_ch.req_height = '0;
    res_ch.ready      = 1'b0;
    model_cols        = SIZE_W'(MAX_COLS);
    model_rows        = SIZE_W'(MAX_ROWS);
    foreach (occ_rows[i]) occ_rows[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // zero sizes, oversize, first fit along the top rows
    push_rect(0, 5);
    push_rect(5, 0);
    push_rect(4095, 4095);
    push_rect(2049, 32);
    push_rect(1, 1);
    push_rect(32, 32);
    push_rect(33, 1);
    push_rect(2048, 32);
    push_rect(32, 2048);
    push_rect(2048, 2048);
    wait_drained();

    // whole atlas, then nothing left
    write_size(CFG_GRID_COLS, 64);
    push_rect(2048, 2048);
    push_rect(1, 1);
    wait_drained();

    // empty atlas
    write_size(CFG_GRID_COLS, 0);
    push_rect(1, 1);
    wait_drained();

    // saturating width, single row
    write_size(CFG_GRID_COLS, 127);
    write_size(CFG_GRID_ROWS, 1);
    push_rect(2048, 32);
    push_rect(1, 33);
    wait_drained();

    write_size(CFG_GRID_ROWS, 0);
    push_rect(1, 1);
    wait_drained();

    // single block atlas
    write_size(CFG_GRID_COLS, 1);
    write_size(CFG_GRID_ROWS, 1);
    push_rect(32, 32);
    push_rect(1, 1);
    wait_drained();

    run_phase(8, 8, 0, 0, 30);
    run_phase(16, 12, 85, 0, 28);
    run_phase(5, 20, 0, 85, 28);
    run_phase(64, 64, 27, 27, 14);
    run_phase(3, 3, 27, 27, 10);
    run_phase(127, 127, 0, 0, 6);

    // receiver held off while requests keep coming
    write_size(CFG_GRID_COLS, 4);
    write_size(CFG_GRID_ROWS, 6);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len       = HOLD_CYCLES;
    @(posedge clk);
    hold_arm <= 1'b1;
    @(posedge clk);
    hold_arm <= 1'b0;
    repeat (15) begin
      rect_q.push_back(rand_rect());
      submitted_cnt++;
    end
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_cnt == 0) begin
      $display("atlas_first_fit_block_placer test passed");
    end else begin
      $display("atlas_first_fit_block_placer test failed");
    end
    $finish;
  end

endmodule

// File: atlas_first_fit_block_placer.f
src/affbp_pkg.sv
src/affbp_req_if.sv
src/affbp_res_if.sv
src/affbp_ctrl.sv
src/affbp_dp.sv
src/atlas_first_fit_block_placer.sv
tb/atlas_first_fit_block_placer_tb.sv
